// ===== design/msh_pkg.sv =====
// ----------------------------------------------------------------------------
// msh_pkg
// Shared types and constants of the mandelbrot pixel shader.
// ----------------------------------------------------------------------------
package msh_pkg;

   localparam int FRAC_BITS_DEF = 28;
   localparam int DIM_BITS      = 12;
   localparam int ITER_BITS     = 16;
   localparam int COORD_W       = 32;
   localparam int SIZE_W        = 13;
   localparam int SHADE_W       = 8;
   // magnitude of (end - start) * index
   localparam int PROD_W        = COORD_W + 1 + DIM_BITS;
   // mapped coordinate, signed
   localparam int C_W           = PROD_W + 1;
   localparam int CSR_IDX_W     = 3;

   localparam logic [COORD_W-1:0] START_RESET = 32'hE000_0000;
   localparam logic [COORD_W-1:0] END_RESET   = 32'h2000_0000;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd256;
   localparam logic [ITER_BITS-1:0] LIMIT_RESET = 16'd1024;
   localparam logic [SHADE_W-1:0] SHADE_MAX   = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_RE = 3'd0,
      CSR_END_RE   = 3'd1,
      CSR_START_IM = 3'd2,
      CSR_END_IM   = 3'd3,
      CSR_ROWS     = 3'd4,
      CSR_COLS     = 3'd5,
      CSR_LIMIT    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] pixel_row;
      logic [DIM_BITS-1:0] pixel_col;
   } req_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] out_row;
      logic [DIM_BITS-1:0] out_col;
      logic [SHADE_W-1:0]  shade;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] start_re;
      logic [COORD_W-1:0] end_re;
      logic [COORD_W-1:0] start_im;
      logic [COORD_W-1:0] end_im;
      logic [SIZE_W-1:0]  image_rows;
      logic [SIZE_W-1:0]  image_cols;
   } cfg_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] row;
      logic [DIM_BITS-1:0] col;
      logic [C_W-1:0]      c_re;
      logic [C_W-1:0]      c_im;
   } work_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_ADD,
      B_SHADE,
      B_DONE
   } back_state_type;

endpackage

// ===== design/msh_front.sv =====
// ----------------------------------------------------------------------------
// msh_front
// Maps pixel row and column onto the complex window, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module msh_front (
   input  logic              clock,
   input  logic              reset,
   input  msh_pkg::cfg_type  cfg,
   input  logic              in_push,
   output logic              in_full,
   input  msh_pkg::req_type  in_data,
   output logic              out_push,
   input  logic              out_full,
   output msh_pkg::work_type out_data
);
   import msh_pkg::*;

   localparam int CNT_W = $clog2(PROD_W + 1);

   front_state_type      state_ff, state_in;
   logic [DIM_BITS-1:0]  row_ff, col_ff;
   logic [PROD_W-1:0]    re_quo_ff, re_quo_in, im_quo_ff, im_quo_in;
   logic [SIZE_W-1:0]    re_rem_ff, re_rem_in, im_rem_ff, im_rem_in;
   logic [SIZE_W-1:0]    re_den_ff, im_den_ff;
   logic                 re_neg_ff, im_neg_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [COORD_W:0]     re_diff, im_diff, re_dmag, im_dmag;
   logic [SIZE_W:0]      re_trial, im_trial;
   logic [C_W-1:0]       re_q, im_q;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: begin
            if (in_push) state_in = F_MUL;
         end
         F_MUL: state_in = F_DIV;
         F_DIV: begin
            if (cnt_ff == CNT_W'(PROD_W - 1)) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!out_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      re_diff  = {cfg.end_re[COORD_W-1], cfg.end_re} - {cfg.start_re[COORD_W-1], cfg.start_re};
      im_diff  = {cfg.end_im[COORD_W-1], cfg.end_im} - {cfg.start_im[COORD_W-1], cfg.start_im};
      re_dmag  = re_diff[COORD_W] ? -re_diff : re_diff;
      im_dmag  = im_diff[COORD_W] ? -im_diff : im_diff;
      re_trial = {re_rem_ff, re_quo_ff[PROD_W-1]};
      im_trial = {im_rem_ff, im_quo_ff[PROD_W-1]};
      re_rem_in = re_trial[SIZE_W-1:0];
      im_rem_in = im_trial[SIZE_W-1:0];
      re_quo_in = {re_quo_ff[PROD_W-2:0], 1'b0};
      im_quo_in = {im_quo_ff[PROD_W-2:0], 1'b0};
      if (re_trial >= {1'b0, re_den_ff}) begin
         re_rem_in    = SIZE_W'(re_trial - {1'b0, re_den_ff});
         re_quo_in[0] = 1'b1;
      end
      if (im_trial >= {1'b0, im_den_ff}) begin
         im_rem_in    = SIZE_W'(im_trial - {1'b0, im_den_ff});
         im_quo_in[0] = 1'b1;
      end
      re_q = {1'b0, re_quo_ff};
      im_q = {1'b0, im_quo_ff};
      out_data.row  = row_ff;
      out_data.col  = col_ff;
      out_data.c_re = C_W'($signed(cfg.start_re)) + (re_neg_ff ? -re_q : re_q);
      out_data.c_im = C_W'($signed(cfg.start_im)) + (im_neg_ff ? -im_q : im_q);
      in_full  = (state_ff != F_IDLE);
      out_push = (state_ff == F_PUSH) && !out_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            if (in_push) begin
               row_ff <= in_data.pixel_row;
               col_ff <= in_data.pixel_col;
            end
         end
         F_MUL: begin
            re_quo_ff <= PROD_W'(re_dmag * col_ff);
            im_quo_ff <= PROD_W'(im_dmag * row_ff);
            re_neg_ff <= re_diff[COORD_W];
            im_neg_ff <= im_diff[COORD_W];
            // a size of zero counts as one
            re_den_ff <= (cfg.image_cols == '0) ? SIZE_W'(1) : cfg.image_cols;
            im_den_ff <= (cfg.image_rows == '0) ? SIZE_W'(1) : cfg.image_rows;
            re_rem_ff <= '0;
            im_rem_ff <= '0;
            cnt_ff    <= '0;
         end
         F_DIV: begin
            re_quo_ff <= re_quo_in;
            im_quo_ff <= im_quo_in;
            re_rem_ff <= re_rem_in;
            im_rem_ff <= im_rem_in;
            cnt_ff    <= cnt_ff + CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/msh_queue.sv =====
// ----------------------------------------------------------------------------
// msh_queue
// Two-entry queue of mapped points between front and back.
// ----------------------------------------------------------------------------
module msh_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  msh_pkg::work_type push_data,
   input  logic              pop,
   output logic              empty,
   output msh_pkg::work_type pop_data
);
   import msh_pkg::*;

   work_type    mem_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !full && !(pop && !empty)) count_in = count_ff + 2'd1;
      if (!(push && !full) && pop && !empty) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push && !full) wr_ptr_ff <= !wr_ptr_ff;
         if (pop && !empty) rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== design/msh_back.sv =====
// ----------------------------------------------------------------------------
// msh_back
// Escape-time iteration of z = z*z + c and shade scaling of the count.
// ----------------------------------------------------------------------------
module msh_back #(
   parameter int FRAC_BITS = msh_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [msh_pkg::ITER_BITS-1:0]  limit,
   output logic                           in_pop,
   input  logic                           in_empty,
   input  msh_pkg::work_type              in_data,
   output logic                           out_empty,
   input  logic                           out_pop,
   output msh_pkg::rsp_type               out_data
);
   import msh_pkg::*;

   localparam int M_W   = FRAC_BITS + 1;
   localparam int P_W   = 2 * M_W;
   localparam int Z_W   = ((C_W > FRAC_BITS + 3) ? C_W : FRAC_BITS + 3) + 1;
   localparam int SH_W  = P_W - FRAC_BITS;
   localparam int DV_W  = ITER_BITS + 8;
   localparam int DC_W  = $clog2(DV_W + 1);

   back_state_type       state_ff, state_in;
   logic [DIM_BITS-1:0]  row_ff, col_ff;
   logic [Z_W-1:0]       cr_ff, ci_ff, zr_ff, zi_ff, zr_in, zi_in;
   logic [P_W-1:0]       sr_ff, si_ff, cx_ff;
   logic                 big_ff;
   logic [ITER_BITS-1:0] iter_ff;
   logic [DV_W-1:0]      quo_ff, quo_in;
   logic [ITER_BITS-1:0] rem_ff, rem_in;
   logic [DC_W-1:0]      dcnt_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff;
   logic [Z_W-1:0]       ar_full, ai_full;
   logic [M_W-1:0]       ar, ai;
   logic [P_W:0]         mag_sq;
   logic                 escape, at_limit, load_rsp;
   logic [P_W-1:0]       dif;
   logic [SH_W-1:0]      dsh;
   logic [FRAC_BITS+2:0] msh;
   logic [Z_W-1:0]       nr, ni;
   logic [ITER_BITS:0]   trial;

   always_comb begin
      ar_full = zr_ff[Z_W-1] ? -zr_ff : zr_ff;
      ai_full = zi_ff[Z_W-1] ? -zi_ff : zi_ff;
      ar      = ar_full[M_W-1:0];
      ai      = ai_full[M_W-1:0];
      mag_sq  = {1'b0, sr_ff} + {1'b0, si_ff};
      // |z|^2 >= 4, or a component already at 2 or more
      escape   = (iter_ff != '0) && (big_ff || mag_sq >= ((P_W+1)'(1) << (2 * FRAC_BITS + 2)));
      at_limit = (iter_ff == limit);
      dif = (sr_ff >= si_ff) ? sr_ff - si_ff : si_ff - sr_ff;
      dsh = SH_W'(dif >> FRAC_BITS);
      nr  = (sr_ff >= si_ff) ? Z_W'(dsh) : -Z_W'(dsh);
      msh = (FRAC_BITS+3)'(cx_ff >> (FRAC_BITS - 1));
      ni  = (zr_ff[Z_W-1] != zi_ff[Z_W-1]) ? -Z_W'(msh) : Z_W'(msh);
      zr_in = nr + cr_ff;
      zi_in = ni + ci_ff;
      trial  = {rem_ff, quo_ff[DV_W-1]};
      quo_in = {quo_ff[DV_W-2:0], 1'b0};
      rem_in = trial[ITER_BITS-1:0];
      if (trial >= {1'b0, limit}) begin
         rem_in    = ITER_BITS'(trial - {1'b0, limit});
         quo_in[0] = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!in_empty) state_in = B_MUL;
         end
         B_MUL: state_in = B_ADD;
         B_ADD: begin
            if (escape) state_in = B_SHADE;
            else if (at_limit) state_in = B_DONE;
            else state_in = B_MUL;
         end
         B_SHADE: begin
            if (dcnt_ff == DC_W'(DV_W - 1)) state_in = B_DONE;
         end
         B_DONE: begin
            if (load_rsp) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      in_pop    = (state_ff == B_IDLE) && !in_empty;
      load_rsp  = (state_ff == B_DONE) && (!rsp_valid_ff || out_pop);
      out_empty = !rsp_valid_ff;
      out_data  = rsp_ff;
      rsp_in.out_row = row_ff;
      rsp_in.out_col = col_ff;
      rsp_in.shade   = (quo_ff >= DV_W'(32)) ? SHADE_MAX : {quo_ff[4:0], 3'b000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (out_pop) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) rsp_ff <= rsp_in;
      case (state_ff)
         B_IDLE: begin
            row_ff  <= in_data.row;
            col_ff  <= in_data.col;
            cr_ff   <= Z_W'($signed(in_data.c_re));
            ci_ff   <= Z_W'($signed(in_data.c_im));
            zr_ff   <= '0;
            zi_ff   <= '0;
            iter_ff <= '0;
            quo_ff  <= '0;
         end
         B_MUL: begin
            sr_ff  <= P_W'(ar * ar);
            si_ff  <= P_W'(ai * ai);
            cx_ff  <= P_W'(ar * ai);
            big_ff <= ((ar_full >> M_W) != '0) || ((ai_full >> M_W) != '0);
         end
         B_ADD: begin
            if (escape) begin
               // count * 255 as dividend
               quo_ff  <= (DV_W'(iter_ff) << 8) - DV_W'(iter_ff);
               rem_ff  <= '0;
               dcnt_ff <= '0;
            end else if (!at_limit) begin
               zr_ff   <= zr_in;
               zi_ff   <= zi_in;
               iter_ff <= iter_ff + ITER_BITS'(1);
            end
         end
         B_SHADE: begin
            quo_ff  <= quo_in;
            rem_ff  <= rem_in;
            dcnt_ff <= dcnt_ff + DC_W'(1);
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/mandelbrot_pixel_shader.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_shader
// Escape-time shader: pixel position in, row, column and 8-bit shade out.
// ----------------------------------------------------------------------------
// One pixel at a time passes the front, which maps it onto the window with a
// multiply and a radix-2 divider, then waits in a two-entry queue for the
// back. The back runs each orbit step as a square, then an add and escape
// test, for up to the iteration limit, followed by a bit-serial shade
// division for escaping points.
// Results wait in an output register and are taken with pop.
module mandelbrot_pixel_shader #(
   parameter int FRAC_BITS = msh_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  msh_pkg::req_type               req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output msh_pkg::rsp_type               rsp_data,
   input  logic                           csr_wen,
   input  logic [msh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [msh_pkg::COORD_W-1:0]    csr_wdata
);
   import msh_pkg::*;

   cfg_type              cfg_ff;
   logic [ITER_BITS-1:0] limit_ff;
   logic                 q_push, q_full, q_pop, q_empty;
   work_type             q_in, q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_re   <= START_RESET;
         cfg_ff.end_re     <= END_RESET;
         cfg_ff.start_im   <= START_RESET;
         cfg_ff.end_im     <= END_RESET;
         cfg_ff.image_rows <= SIZE_RESET;
         cfg_ff.image_cols <= SIZE_RESET;
         limit_ff          <= LIMIT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_START_RE: cfg_ff.start_re   <= csr_wdata;
            CSR_END_RE:   cfg_ff.end_re     <= csr_wdata;
            CSR_START_IM: cfg_ff.start_im   <= csr_wdata;
            CSR_END_IM:   cfg_ff.end_im     <= csr_wdata;
            CSR_ROWS:     cfg_ff.image_rows <= csr_wdata[SIZE_W-1:0];
            CSR_COLS:     cfg_ff.image_cols <= csr_wdata[SIZE_W-1:0];
            CSR_LIMIT:    limit_ff          <= csr_wdata[ITER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   msh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_push  (req_push),
      .in_full  (req_full),
      .in_data  (req_data),
      .out_push (q_push),
      .out_full (q_full),
      .out_data (q_in)
   );

   msh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_in),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   msh_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .limit     (limit_ff),
      .in_pop    (q_pop),
      .in_empty  (q_empty),
      .in_data   (q_out),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_data  (rsp_data)
   );

endmodule
